// ===== sv/qfs_pkg.sv =====
// Shared types, register map and character-class helper for the quoted field splitter.
package qfs_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned MAX_SLOTS  = 8;

    // register index, taken from paddr[4:3] (registers lie on 8-byte boundaries)
    typedef enum logic [1:0] {
        REG_SEPARATOR = 2'd0,
        REG_ESCAPE    = 2'd1,
        REG_QUOTE     = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       field_end;
        logic       string_done;
    } result_t;

    // true when c matches a nonzero slot among the low 'slots' byte slots of the set
    function automatic logic in_set(
        input logic [CFG_DATA_W-1:0] set,
        input logic [7:0]            c,
        input int unsigned           slots
    );
        logic hit;
        hit = 1'b0;
        for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
            if (i < slots && set[8*i +: 8] != 8'd0 && set[8*i +: 8] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== sv/quoted_field_splitter.sv =====
// Quoted field splitter: character stream in, field characters and end marks out.
//
// Input channel: one character per transfer (in_valid/in_stall/in_char); a zero
// character ends the string. Output channel: one result per transfer carrying
// out_char/char_valid (a field character), field_end (field complete, may be an
// empty quoted field) and string_done (end-of-string result, always given).
// Escape arming, quote opening and skipped separators give no result.
// Separator, escape and quote sets are written over the APB port at byte
// addresses 0, 8 and 16; the user must write them only while no string is in
// flight, which the block does not enforce. One character per cycle is taken
// while in_stall is low; the character state (escape, open quote, field
// nonempty) updates as a character leaves the input register and any result
// loads the output register. in_stall rises only while the input register
// holds a character that makes a result and the output register is full and
// stalled. Reset clears the sets, the character state and both valid flags.
module quoted_field_splitter
    import qfs_pkg::*;
#(
    parameter int unsigned SET_SLOTS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // character input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            in_char,
    // result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_char,
    output logic                  char_valid,
    output logic                  field_end,
    output logic                  string_done
);

    localparam int unsigned SET_BITS = 8 * SET_SLOTS;

    logic [SET_BITS-1:0] sep_set_reg;
    logic [SET_BITS-1:0] esc_set_reg;
    logic [SET_BITS-1:0] quote_set_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;

    logic       esc_reg,      esc_next;
    logic [7:0] quote_reg,    quote_next;
    logic       nonempty_reg, nonempty_next;

    logic    out_valid_reg;
    result_t out_reg;

    logic    res_gen;
    result_t res;
    logic    out_free;
    logic    s1_go;
    logic    wr_en;
    reg_idx_t wr_idx;

    logic [CFG_DATA_W-1:0] sep_ext, esc_ext, quote_ext;

    assign sep_ext   = CFG_DATA_W'(sep_set_reg);
    assign esc_ext   = CFG_DATA_W'(esc_set_reg);
    assign quote_ext = CFG_DATA_W'(quote_set_reg);

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sep_set_reg   <= '0;
            esc_set_reg   <= '0;
            quote_set_reg <= '0;
        end else if (wr_en) begin
            unique case (wr_idx)
                REG_SEPARATOR: sep_set_reg   <= pwdata[SET_BITS-1:0];
                REG_ESCAPE:    esc_set_reg   <= pwdata[SET_BITS-1:0];
                REG_QUOTE:     quote_set_reg <= pwdata[SET_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_SEPARATOR: prdata = sep_ext;
            REG_ESCAPE:    prdata = esc_ext;
            REG_QUOTE:     prdata = quote_ext;
            default:       prdata = '0;
        endcase
    end

    // ---------------- character classification ----------------
    always_comb begin
        esc_next      = esc_reg;
        quote_next    = quote_reg;
        nonempty_next = nonempty_reg;
        res_gen       = 1'b0;
        res           = '0;
        if (s1_char_reg == 8'd0) begin
            esc_next        = 1'b0;
            quote_next      = 8'd0;
            nonempty_next   = 1'b0;
            res_gen         = 1'b1;
            res.field_end   = nonempty_reg;
            res.string_done = 1'b1;
        end else if (esc_reg) begin
            esc_next       = 1'b0;
            nonempty_next  = 1'b1;
            res_gen        = 1'b1;
            res.out_char   = s1_char_reg;
            res.char_valid = 1'b1;
        end else if (quote_reg != 8'd0) begin
            res_gen = 1'b1;
            if (s1_char_reg == quote_reg) begin
                quote_next    = 8'd0;
                nonempty_next = 1'b0;
                res.field_end = 1'b1;
            end else begin
                nonempty_next  = 1'b1;
                res.out_char   = s1_char_reg;
                res.char_valid = 1'b1;
            end
        end else if (in_set(esc_ext, s1_char_reg, SET_SLOTS)) begin
            esc_next = 1'b1;
        end else if (!nonempty_reg && in_set(quote_ext, s1_char_reg, SET_SLOTS)) begin
            quote_next = s1_char_reg;
        end else if (in_set(sep_ext, s1_char_reg, SET_SLOTS)) begin
            // separator runs are skipped; only a nonempty field is closed
            if (nonempty_reg) begin
                nonempty_next = 1'b0;
                res_gen       = 1'b1;
                res.field_end = 1'b1;
            end
        end else begin
            nonempty_next  = 1'b1;
            res_gen        = 1'b1;
            res.out_char   = s1_char_reg;
            res.char_valid = 1'b1;
        end
    end

    // ---------------- flow control ----------------
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!res_gen || out_free);
    assign in_stall = s1_valid_reg && !s1_go;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (!in_stall && in_valid) begin
            s1_char_reg <= in_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            esc_reg      <= 1'b0;
            quote_reg    <= 8'd0;
            nonempty_reg <= 1'b0;
        end else if (s1_go) begin
            esc_reg      <= esc_next;
            quote_reg    <= quote_next;
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= s1_go && res_gen;
        end
    end

    always_ff @(posedge clk) begin
        if (out_free && s1_go && res_gen) begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_reg.out_char;
    assign char_valid  = out_reg.char_valid;
    assign field_end   = out_reg.field_end;
    assign string_done = out_reg.string_done;

    // ---------------- assertions ----------------
    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output register could load");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_valid) |-> (!field_end && !string_done))
        else $error("character result also carries an end mark");

    a_unused_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !char_valid) |-> (out_char == 8'd0))
        else $error("out_char nonzero on a mark-only result");

    a_eos_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_char_reg == 8'd0) |=> (!esc_reg && quote_reg == 8'd0 && !nonempty_reg))
        else $error("end of string did not return state to reset");

endmodule
